@@ design/hcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants of the chunked body decoder
// Decoder phases, result kinds, the result record and hex digit decoding.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int DEF_SIZE_BITS  = 32;
  localparam int HEX_DIGIT_BITS = 4;
  localparam int COUNT_BITS     = 32;
  localparam int HDR_BITS       = 16;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SIZE    = 3'd1,
    PH_SIZE_LF = 3'd2,
    PH_DATA    = 3'd3,
    PH_DATA_CR = 3'd4,
    PH_DATA_LF = 3'd5,
    PH_LAST_CR = 3'd6,
    PH_LAST_LF = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             body_byte;
    logic [COUNT_BITS-1:0]  total_consumed;
  } result_t;

  typedef struct packed {
    logic                      ok;
    logic [HEX_DIGIT_BITS-1:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = HEX_DIGIT_BITS'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = HEX_DIGIT_BITS'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = HEX_DIGIT_BITS'(c - 8'h37);
    end
    return h;
  endfunction

endpackage

@@ design/hcbd_core.sv @@
// ----------------------------------------------------------------------------
// hcbd_core: chunk framing state and per-byte step logic
// Holds phase, chunk size/remaining count and consumed count; produces one
// result record for every accepted byte.
// ----------------------------------------------------------------------------
module hcbd_core
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = DEF_SIZE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 start_of_body,
  input  logic [HDR_BITS-1:0]  header_bytes,
  output result_t              result
);

  phase_t                phase_r, phase_nxt, phase_cur;
  logic [SIZE_BITS-1:0]  chunk_r, chunk_nxt, chunk_cur;
  logic                  seen_r, seen_nxt, seen_cur;
  logic [COUNT_BITS-1:0] count_r, count_nxt, count_cur;
  hex_t                  hex;
  kind_t                 kind;

  always_comb begin
    phase_cur = start_of_body ? PH_SIZE : phase_r;
    chunk_cur = start_of_body ? '0 : chunk_r;
    seen_cur  = start_of_body ? 1'b0 : seen_r;
    count_cur = start_of_body ? COUNT_BITS'(header_bytes) : count_r;
    hex       = hex_value(data_byte);

    phase_nxt = phase_cur;
    chunk_nxt = chunk_cur;
    seen_nxt  = seen_cur;
    count_nxt = count_cur;
    kind      = KIND_NONE;
    result    = '0;

    if (phase_cur != PH_IDLE) begin
      if (count_cur != '1) begin
        count_nxt = count_cur + COUNT_BITS'(1);
      end
      unique case (phase_cur)
        PH_IDLE: begin
          kind = KIND_NONE;
        end
        PH_SIZE: begin
          if (hex.ok) begin
            if (chunk_cur[SIZE_BITS-1 -: HEX_DIGIT_BITS] != '0) begin
              kind = KIND_ERROR;
            end else begin
              chunk_nxt = {chunk_cur[SIZE_BITS-HEX_DIGIT_BITS-1:0], hex.val};
              seen_nxt  = 1'b1;
            end
          end else if (data_byte == CHAR_CR && seen_cur) begin
            phase_nxt = PH_SIZE_LF;
          end else begin
            kind = KIND_ERROR;
          end
        end
        PH_SIZE_LF: begin
          if (data_byte != CHAR_LF) begin
            kind = KIND_ERROR;
          end else begin
            phase_nxt = (chunk_cur == '0) ? PH_LAST_CR : PH_DATA;
          end
        end
        PH_DATA: begin
          kind             = KIND_DATA;
          result.body_byte = data_byte;
          if (chunk_cur != '0) begin
            chunk_nxt = chunk_cur - SIZE_BITS'(1);
          end
          if (chunk_nxt == '0) begin
            phase_nxt = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (data_byte == CHAR_CR) begin
            phase_nxt = PH_DATA_LF;
          end else begin
            kind = KIND_ERROR;
          end
        end
        PH_DATA_LF: begin
          if (data_byte == CHAR_LF) begin
            phase_nxt = PH_SIZE;
            chunk_nxt = '0;
            seen_nxt  = 1'b0;
          end else begin
            kind = KIND_ERROR;
          end
        end
        PH_LAST_CR: begin
          if (data_byte == CHAR_CR) begin
            phase_nxt = PH_LAST_LF;
          end else begin
            kind = KIND_ERROR;
          end
        end
        PH_LAST_LF: begin
          if (data_byte == CHAR_LF) begin
            kind                  = KIND_DONE;
            result.total_consumed = count_nxt;
            phase_nxt             = PH_IDLE;
          end else begin
            kind = KIND_ERROR;
          end
        end
      endcase
      if (kind == KIND_ERROR) begin
        phase_nxt = PH_IDLE;
      end
    end
    result.kind = kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      chunk_r <= '0;
      seen_r  <= 1'b0;
      count_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      chunk_r <= chunk_nxt;
      seen_r  <= seen_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> chunk_r != '0)
    else $error("data phase with zero bytes remaining");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (result.kind == KIND_DONE || result.kind == KIND_ERROR)
      |=> phase_r == PH_IDLE)
    else $error("decoder not idle after completion or error");

  a_idle_none: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE && !start_of_body |-> result.kind == KIND_NONE)
    else $error("result produced while idle");
`endif

endmodule

@@ design/hcbd_skid.sv @@
// ----------------------------------------------------------------------------
// hcbd_skid: result register with skid stage
// Holds one result for the output channel and one more while it stalls.
// ----------------------------------------------------------------------------
module hcbd_skid
  import hcbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  result_t in_result,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_result
);

  logic    main_vld_r, main_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    accept;

  assign in_stall   = skid_vld_r;
  assign accept     = in_valid && !skid_vld_r;
  assign out_valid  = main_vld_r;
  assign out_result = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (!out_stall) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!main_vld_r || !out_stall) begin
        main_nxt     = in_result;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = in_result;
        skid_vld_nxt = 1'b1;
      end
    end else if (!out_stall) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

`ifndef ASSERT_OFF
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid entry without result entry");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept && main_vld_r && out_stall |=> skid_vld_r)
    else $error("request lost while output stalled");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && !out_stall |=> !skid_vld_r && main_vld_r)
    else $error("skid entry not moved forward");
`endif

endmodule

@@ design/http_chunked_body_decoder.sv @@
// An accepted byte's result is registered in the result entry, or in the skid entry while the output stalls.
// Throughput: one byte per cycle while the skid entry is empty; the state update is a single step per byte.
// A two-entry result buffer takes one more result while the output stalls, then stalls the input.
// Reset (rst_n low, synchronous): decoder idle, counts zero, buffer empty.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer decoder
// Decodes chunk size lines and data, emits body bytes, completion or error.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = DEF_SIZE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_start_of_body,
  input  logic [HDR_BITS-1:0]   in_header_bytes,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_body_byte,
  output logic [COUNT_BITS-1:0] out_total_consumed
);

  result_t step_result;
  result_t out_result;
  logic    accept;

  assign accept = in_valid && !in_stall;

  hcbd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .start_of_body(in_start_of_body),
    .header_bytes (in_header_bytes),
    .result       (step_result)
  );

  hcbd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_result (step_result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(out_result)
  );

  assign out_kind           = out_result.kind;
  assign out_body_byte      = out_result.body_byte;
  assign out_total_consumed = out_result.total_consumed;

endmodule
